// ----- design/vzsc_pkg.sv -----
// ----------------------------------------------------------------------------
// vzsc_pkg
// Shared types and constants for the vertical height spread checker.
// ----------------------------------------------------------------------------
package vzsc_pkg;

  localparam int MAX_BINS    = 64;
  localparam int Z_WIDTH     = 24;
  localparam int COUNT_WIDTH = 16;

  localparam int SPAN_W      = 23;
  localparam int MINSEP_W    = 16;
  localparam int SCALE_W     = 24;
  localparam int SCALE_SHIFT = 24;
  localparam int BINS_W      = 7;

  localparam int CALC_W   = ((Z_WIDTH > SPAN_W) ? Z_WIDTH : SPAN_W) + 2;
  localparam int BIN_W    = CALC_W - 1;
  localparam int PROD_W   = BIN_W + SCALE_W;
  localparam int BIDX_W   = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int CNTCMP_W = (COUNT_WIDTH > MINSEP_W) ? COUNT_WIDTH : MINSEP_W;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  typedef enum logic [2:0] {
    REG_ENABLED,
    REG_MIN_Z_SPAN,
    REG_SEP_THRESHOLD,
    REG_MIN_SEP_POINTS,
    REG_Z_WINDOW,
    REG_INV_BIN_SCALE,
    REG_BIN_COUNT,
    REG_MIN_OCC_BINS
  } reg_index_t;

  typedef struct packed {
    logic                enabled;
    logic [SPAN_W-1:0]   span_min;
    logic [SPAN_W-1:0]   sep_thresh;
    logic [MINSEP_W-1:0] sep_points_min;
    logic [SPAN_W-1:0]   win_half;
    logic [SCALE_W-1:0]  inv_bin_scale;
    logic [BINS_W-1:0]   bins_used;
    logic [BINS_W-1:0]   occ_bins_min;
  } cfg_t;

  typedef struct packed {
    logic                       first;
    logic                       last;
    logic                       empty_query;
    logic                       query_ok;
    logic signed [Z_WIDTH-1:0]  query_z;
    logic                       neighbor_ok;
    logic signed [Z_WIDTH-1:0]  neighbor_z;
  } nbr_item_t;

  typedef struct packed {
    logic vertical;
    logic span_met;
    logic separated_met;
    logic bins_met;
    logic input_fault;
  } verdict_t;

endpackage

// ----- design/vzsc_regs.sv -----
// ----------------------------------------------------------------------------
// vzsc_regs
// APB register file holding the checker thresholds and bin setup.
// ----------------------------------------------------------------------------
module vzsc_regs
  import vzsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  reg_index_t idx;
  logic       wr_en;

  assign pready = 1'b1;
  assign idx    = reg_index_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enabled        <= 1'b0;
      cfg.span_min       <= SPAN_W'(1024);
      cfg.sep_thresh     <= SPAN_W'(512);
      cfg.sep_points_min <= MINSEP_W'(1);
      cfg.win_half       <= SPAN_W'(1024);
      cfg.inv_bin_scale  <= SCALE_W'(1048576);
      cfg.bins_used      <= BINS_W'(16);
      cfg.occ_bins_min   <= BINS_W'(1);
    end else if (wr_en) begin
      unique case (idx)
        REG_ENABLED:        cfg.enabled        <= pwdata[0];
        REG_MIN_Z_SPAN:     cfg.span_min       <= pwdata[SPAN_W-1:0];
        REG_SEP_THRESHOLD:  cfg.sep_thresh     <= pwdata[SPAN_W-1:0];
        REG_MIN_SEP_POINTS: cfg.sep_points_min <= pwdata[MINSEP_W-1:0];
        REG_Z_WINDOW:       cfg.win_half       <= pwdata[SPAN_W-1:0];
        REG_INV_BIN_SCALE:  cfg.inv_bin_scale  <= pwdata[SCALE_W-1:0];
        REG_BIN_COUNT:      cfg.bins_used      <= pwdata[BINS_W-1:0];
        REG_MIN_OCC_BINS:   cfg.occ_bins_min   <= pwdata[BINS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ENABLED:        prdata = DATA_W'(cfg.enabled);
      REG_MIN_Z_SPAN:     prdata = DATA_W'(cfg.span_min);
      REG_SEP_THRESHOLD:  prdata = DATA_W'(cfg.sep_thresh);
      REG_MIN_SEP_POINTS: prdata = DATA_W'(cfg.sep_points_min);
      REG_Z_WINDOW:       prdata = DATA_W'(cfg.win_half);
      REG_INV_BIN_SCALE:  prdata = DATA_W'(cfg.inv_bin_scale);
      REG_BIN_COUNT:      prdata = DATA_W'(cfg.bins_used);
      REG_MIN_OCC_BINS:   prdata = DATA_W'(cfg.occ_bins_min);
      default:            prdata = '0;
    endcase
  end

endmodule

// ----- design/vertical_z_spread_check.sv -----
// ----------------------------------------------------------------------------
// vertical_z_spread_check
// Items pass through the s1, s2 and s3 registers to the registered verdict.
// Throughput: one item per cycle unless verdict_stall holds the output; min/max/count
// update in the input stage, the bin multiply result is registered, the bin map popcount has its own stage.
// Reset: synchronous; clears the pipeline, the accumulators and the bin map,
// and loads the register defaults.
// ----------------------------------------------------------------------------
module vertical_z_spread_check
  import vzsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              query_valid,
  output logic              query_stall,
  input  nbr_item_t         query_item,
  output logic              verdict_valid,
  input  logic              verdict_stall,
  output verdict_t          verdict
);

  typedef struct packed {
    logic             last;
    logic             empty_query;
    logic             clear_map;
    logic             hit_try;
    logic [BIN_W-1:0] bin;
  } s2_t;

  typedef struct packed {
    logic last;
    logic empty_query;
    logic fault;
    logic span;
    logic sep;
  } s3_t;

  cfg_t cfg;

  vzsc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // pipeline registers
  logic      s1_valid, s2_valid, s3_valid;
  nbr_item_t s1;
  s2_t       s2, s2_next;
  s3_t       s3, s3_next;

  // accumulators
  logic signed [Z_WIDTH-1:0] held_z, lowest_z, highest_z;
  logic signed [Z_WIDTH-1:0] held_z_next, lowest_z_next, highest_z_next;
  logic [COUNT_WIDTH-1:0]    sep_count, sep_count_next;
  logic                      fault_seen, fault_seen_next;
  logic [MAX_BINS-1:0]       bin_map, bin_map_next;

  // flow control
  logic ld_out, adv_s3, adv_s2, adv_s1;
  logic s3_free, s2_free, s1_free, s3_res;

  assign s3_res  = s3.last || s3.empty_query;
  assign ld_out  = !verdict_valid || !verdict_stall;
  assign adv_s3  = s3_valid && (!s3_res || ld_out);
  assign s3_free = !s3_valid || adv_s3;
  assign adv_s2  = s2_valid && s3_free;
  assign s2_free = !s2_valid || adv_s2;
  assign adv_s1  = s1_valid && s2_free;
  assign s1_free = !s1_valid || adv_s1;
  assign query_stall = !s1_free;

  // stage 1: accumulate and scale the window offset
  logic signed [Z_WIDTH-1:0] lo_base, hi_base;
  logic signed [CALC_W-1:0]  held_ext, nz_ext, dz, win, offs;
  logic [BIN_W-1:0]          adz;
  logic [PROD_W-1:0]         prod;
  logic                      in_win;

  always_comb begin
    held_ext = s1.first ? CALC_W'($signed(s1.query_z)) : CALC_W'(held_z);
    nz_ext   = CALC_W'($signed(s1.neighbor_z));
    dz       = nz_ext - held_ext;
    adz      = dz[CALC_W-1] ? BIN_W'(-dz) : BIN_W'(dz);
    win      = $signed(CALC_W'(cfg.win_half));
    in_win   = (dz >= -win) && (dz < win);
    offs     = dz + win;
    prod     = PROD_W'(offs[BIN_W-1:0]) * PROD_W'(cfg.inv_bin_scale);

    lo_base         = s1.first ? $signed(s1.query_z) : lowest_z;
    hi_base         = s1.first ? $signed(s1.query_z) : highest_z;
    held_z_next     = s1.first ? $signed(s1.query_z) : held_z;
    sep_count_next  = s1.first ? '0 : sep_count;
    fault_seen_next = s1.first ? !s1.query_ok : fault_seen;
    lowest_z_next   = lo_base;
    highest_z_next  = hi_base;

    if (!s1.neighbor_ok) begin
      fault_seen_next = 1'b1;
    end else begin
      if ($signed(s1.neighbor_z) < lo_base) lowest_z_next = $signed(s1.neighbor_z);
      if ($signed(s1.neighbor_z) > hi_base) highest_z_next = $signed(s1.neighbor_z);
      if ((adz >= BIN_W'(cfg.sep_thresh)) && (sep_count_next < COUNT_MAX)) begin
        sep_count_next = sep_count_next + COUNT_WIDTH'(1);
      end
    end

    if (s1.empty_query) begin
      held_z_next     = '0;
      lowest_z_next   = '0;
      highest_z_next  = '0;
      sep_count_next  = '0;
      fault_seen_next = 1'b0;
    end

    s2_next.last        = s1.last;
    s2_next.empty_query = s1.empty_query;
    s2_next.clear_map   = s1.first || s1.empty_query;
    s2_next.hit_try     = s1.neighbor_ok && in_win && !s1.empty_query;
    s2_next.bin         = prod[PROD_W-1:SCALE_SHIFT];
  end

  // stage 2: set the bin bit, judge span and separation
  logic signed [CALC_W-1:0] span_diff;
  logic                     hit;

  always_comb begin
    span_diff = CALC_W'(highest_z) - CALC_W'(lowest_z);
    hit = s2.hit_try && (s2.bin < BIN_W'(cfg.bins_used)) && (s2.bin < BIN_W'(MAX_BINS));
    bin_map_next = s2.clear_map ? '0 : bin_map;
    if (hit) bin_map_next = bin_map_next | (MAX_BINS'(1) << s2.bin[BIDX_W-1:0]);

    s3_next.last        = s2.last;
    s3_next.empty_query = s2.empty_query;
    s3_next.fault       = fault_seen || !cfg.enabled;
    s3_next.span        = span_diff >= $signed(CALC_W'(cfg.span_min));
    s3_next.sep = CNTCMP_W'(sep_count) >= CNTCMP_W'(cfg.sep_points_min);
  end

  // stage 3: count occupied bins and form the verdict
  logic [BINS_W-1:0] occ;
  logic              flt, bins_ok;
  verdict_t          verdict_next;

  always_comb begin
    occ     = BINS_W'($countones(bin_map));
    bins_ok = occ >= cfg.occ_bins_min;
    flt     = s3.empty_query || s3.fault;
    verdict_next.input_fault   = flt;
    verdict_next.span_met      = !flt && s3.span;
    verdict_next.separated_met = !flt && s3.sep;
    verdict_next.bins_met      = !flt && bins_ok;
    verdict_next.vertical      = !flt && s3.span && s3.sep && bins_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      s3_valid      <= 1'b0;
      verdict_valid <= 1'b0;
      held_z        <= '0;
      lowest_z      <= '0;
      highest_z     <= '0;
      sep_count     <= '0;
      fault_seen    <= 1'b0;
      bin_map       <= '0;
    end else begin
      if (s1_free) s1_valid <= query_valid;
      if (s2_free) s2_valid <= adv_s1;
      if (s3_free) s3_valid <= adv_s2;
      if (ld_out) verdict_valid <= adv_s3 && s3_res;
      if (adv_s1) begin
        held_z     <= held_z_next;
        lowest_z   <= lowest_z_next;
        highest_z  <= highest_z_next;
        sep_count  <= sep_count_next;
        fault_seen <= fault_seen_next;
      end
      if (adv_s2) bin_map <= bin_map_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free) s1 <= query_item;
    if (adv_s1) s2 <= s2_next;
    if (adv_s2) s3 <= s3_next;
    if (ld_out) verdict <= verdict_next;
  end

endmodule

// ----- design/vzsc_checker.sv -----
// ----------------------------------------------------------------------------
// vzsc_checker
// Port-level checks on verdict consistency, output hold, empty-query stall and reset.
// ----------------------------------------------------------------------------
module vzsc_checker
  import vzsc_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              query_valid,
  input logic              query_stall,
  input nbr_item_t         query_item,
  input logic              verdict_valid,
  input logic              verdict_stall,
  input verdict_t          verdict
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    verdict_valid && verdict_stall |=> verdict_valid && $stable(verdict))
    else $error("stalled item changed");

  a_vertical: assert property (@(posedge clk) disable iff (rst)
    verdict_valid && verdict.vertical |->
      verdict.span_met && verdict.separated_met && verdict.bins_met &&
      !verdict.input_fault)
    else $error("vertical without all conditions");

  a_fault: assert property (@(posedge clk) disable iff (rst)
    verdict_valid && verdict.input_fault |->
      !verdict.span_met && !verdict.separated_met && !verdict.bins_met &&
      !verdict.vertical)
    else $error("condition flag set on faulted item");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    query_valid && query_item.empty_query && !verdict_valid |-> !query_stall)
    else $error("empty query stalled with output free");

  a_reset: assert property (@(posedge clk)
    rst |=> !verdict_valid)
    else $error("item out of reset");

endmodule

bind vertical_z_spread_check vzsc_checker u_checker (.*);
